FILE: rtl/line_sensor_steering_controller_macros.svh
// Assertion macros for the line sensor steering controller.
`ifndef LINE_SENSOR_STEERING_CONTROLLER_MACROS_SVH
`define LINE_SENSOR_STEERING_CONTROLLER_MACROS_SVH
`ifndef ASSERT_OFF
`define LSSC_ASSERT(label, clk_s, rst_s, prop) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error("%m failed");
`define LSSC_ASSERT_RST(label, clk_s, prop) \
  label: assert property (@(posedge clk_s) prop) else $error("%m failed");
`else
`define LSSC_ASSERT(label, clk_s, rst_s, prop)
`define LSSC_ASSERT_RST(label, clk_s, prop)
`endif
`endif

FILE: rtl/lssc_pkg.sv
// Shared types and constants of the line sensor steering controller.
package lssc_pkg;
  localparam int CHANNELS_DEF   = 8;
  localparam int SAMPLE_MAX     = 1023;
  localparam int STOP_TICKS_DEF = 90;
  localparam int SW             = 10;
  localparam int PCT_W          = 7;
  localparam int ERR_W          = 14;
  localparam int DUTY_W         = 11;
  localparam int MARGIN         = 30;
  localparam logic [SW-1:0] KP_RESET   = 10'd102;
  localparam logic [SW-1:0] BASE_RESET = 10'd700;
  localparam logic REG_KP   = 1'b0;
  localparam logic REG_BASE = 1'b1;
  localparam logic CMD_CAL  = 1'b0;

  // Q8 weight of a channel, cycling every eight channels
  function automatic logic signed [12:0] weight_q8(input logic [3:0] ch);
    logic signed [12:0] w;
    case (ch[2:0])
      3'd0: w = -13'sd2048;
      3'd1: w = -13'sd1024;
      3'd2: w = -13'sd548;
      3'd3: w = -13'sd256;
      3'd4: w = 13'sd282;
      3'd5: w = 13'sd576;
      3'd6: w = 13'sd1075;
      default: w = 13'sd2048;
    endcase
    return w;
  endfunction

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic div_start;
    logic accum;
    logic finish;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_done;
  } dp_stat_t;
endpackage

FILE: rtl/lssc_ctrl.sv
// Sequencer: walks the channels through the shared divider; calibrate words skip it.
module lssc_ctrl import lssc_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_go,
  input  logic     in_run,
  input  logic     out_free,
  input  dp_stat_t stat,
  output logic     busy,
  output logic [$clog2(CHANNELS)-1:0] ch,
  output dp_cmd_t  cmd
);
  localparam int CW = $clog2(CHANNELS);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_START = 5'b00010, S_WAIT = 5'b00100,
    S_FIN = 5'b01000, S_HOLD = 5'b10000
  } state_t;
  state_t state, state_next;
  logic [CW-1:0] ch_next;

  always_comb begin
    state_next = state;
    ch_next = ch;
    cmd = '0;
    case (state)
      S_IDLE: if (in_go) begin
        cmd.load = 1'b1;
        ch_next = '0;
        state_next = in_run ? S_START : S_FIN;
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: if (stat.div_done) begin
        cmd.accum = 1'b1;
        if (ch == CW'(CHANNELS-1)) state_next = S_FIN;
        else begin
          ch_next = ch + 1'b1;
          state_next = S_START;
        end
      end
      S_FIN: state_next = S_HOLD;
      S_HOLD: if (out_free) begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ch <= '0;
    end else begin
      state <= state_next;
      ch <= ch_next;
    end
  end
  assign busy = (state != S_IDLE);
endmodule

FILE: rtl/lssc_div.sv
// Restoring divider: percent = floor(num*100/den), one quotient bit a cycle.
module lssc_div import lssc_pkg::*; #(
  parameter int NW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [NW-1:0] den,
  output logic          done,
  output logic [PCT_W-1:0] quo
);
  localparam int DW = NW + PCT_W;
  logic [DW-1:0] dividend;
  logic [DW:0]   rem;
  logic [NW-1:0] dv;
  logic [$clog2(DW+1)-1:0] cnt;
  logic [DW-1:0] q;
  logic [DW:0]   trial;
  logic          run;

  assign trial = {rem[DW-1:0], dividend[DW-1]} - {{(DW+1-NW){1'b0}}, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == ($clog2(DW+1))'(DW-1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dividend <= DW'(num) * DW'(100);
      dv <= den;
      rem <= '0;
      q <= '0;
    end else if (run) begin
      dividend <= dividend << 1;
      if (!trial[DW]) begin
        rem <= trial;
        q <= {q[DW-2:0], 1'b1};
      end else begin
        rem <= {rem[DW-1:0], dividend[DW-1]};
        q <= {q[DW-2:0], 1'b0};
      end
    end
  end
  assign quo = q[PCT_W-1:0];
endmodule

FILE: rtl/lssc_dp.sv
// Datapath: calibration tables, percent terms, gain and duty outputs.
module lssc_dp import lssc_pkg::*; #(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int STOP_TICKS = STOP_TICKS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  dp_cmd_t cmd,
  input  logic [$clog2(CHANNELS)-1:0] ch,
  input  logic in_run,
  input  logic [CHANNELS*SW-1:0] in_samples,
  input  logic [SW-1:0] kp_q8,
  input  logic [SW-1:0] base_speed,
  output dp_stat_t stat,
  output logic [DUTY_W-1:0] left_duty,
  output logic [DUTY_W-1:0] right_duty,
  output logic signed [ERR_W-1:0] position_error,
  output logic stopped
);
  localparam int CW = $clog2(CHANNELS);
  localparam int SC = $clog2(STOP_TICKS+1);
  logic [SW-1:0] cmin [CHANNELS];
  logic [SW-1:0] cmax [CHANNELS];
  logic [SW-1:0] samp [CHANNELS];
  logic run_q;
  logic [SC-1:0] stop_count;
  logic signed [ERR_W-1:0] err;
  logic [SW-1:0] s, lo, hi;
  logic div_start, div_done;
  logic [PCT_W-1:0] quo, pct;
  logic bypass;
  logic [PCT_W-1:0] bypass_pct;
  logic signed [20:0] prod;
  logic signed [ERR_W-1:0] term;
  logic signed [24:0] gain;
  logic signed [15:0] corr, lim, base_s;

  assign s = samp[ch];
  assign lo = cmin[ch];
  assign hi = cmax[ch];

  // cases settled without the divider
  always_comb begin
    bypass = 1'b1;
    bypass_pct = '0;
    if (hi <= lo || s <= lo) bypass_pct = '0;
    else if (s >= hi) bypass_pct = PCT_W'(100);
    else bypass = 1'b0;
  end
  assign div_start = cmd.div_start & ~bypass;
  assign stat.div_done = div_done | (bypass & ~div_start);

  lssc_div #(.NW(SW)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(s - lo), .den(hi - lo), .done(div_done), .quo(quo)
  );

  assign pct = bypass ? bypass_pct : quo;
  assign prod = $signed({14'd0, pct}) * 21'(weight_q8({{(4-CW){1'b0}}, ch}));
  assign term = ERR_W'(prod / 21'sd256);

  // sample capture, calibration, stop counting and error accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        cmin[i] <= SW'(SAMPLE_MAX);
        cmax[i] <= '0;
      end
      stop_count <= '0;
    end else if (cmd.load) begin
      run_q <= in_run;
      err <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        samp[i] <= in_samples[i*SW +: SW];
        if (!in_run) begin
          if (in_samples[i*SW +: SW] > cmax[i]) cmax[i] <= in_samples[i*SW +: SW];
          if (in_samples[i*SW +: SW] < cmin[i]) cmin[i] <= in_samples[i*SW +: SW];
        end
      end
      if (in_run && in_samples[SW-1:0] == SW'(1) &&
          in_samples[(CHANNELS-1)*SW +: SW] == SW'(1) &&
          stop_count < SC'(STOP_TICKS))
        stop_count <= stop_count + 1'b1;
    end else if (cmd.accum) begin
      err <= err + term;
    end
  end

  // gain and clamp, registered into the output word
  assign gain = $signed({15'd0, kp_q8}) * 25'(err);
  assign base_s = $signed({6'd0, base_speed});
  assign lim = (base_speed > SW'(MARGIN)) ? base_s - 16'sd30 : 16'sd0;
  always_comb begin
    corr = 16'(gain / 25'sd256);
    if (corr > lim) corr = lim;
    else if (corr < -lim) corr = -lim;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      stopped <= (stop_count >= SC'(STOP_TICKS));
      position_error <= run_q ? err : '0;
      if (!run_q || stop_count >= SC'(STOP_TICKS)) begin
        left_duty <= '0;
        right_duty <= '0;
      end else begin
        left_duty <= DUTY_W'(base_s - corr);
        right_duty <= DUTY_W'(base_s + corr);
      end
    end
  end
endmodule

FILE: rtl/line_sensor_steering_controller.sv
// Line sensor steering controller: calibrate words skip the divider; one word in flight,
// the next one can be accepted in the same cycle as the result is presented.
// Throughput is set by the shared percent divider, one quotient bit per cycle,
// walked over the channels in turn (channels outside the span skip it, passing the start and wait states only).
// Synchronous reset loads gain 102, base 700, min to full scale, max to 0, stop count 0.
// The result word is held in an output register until taken.
`include "line_sensor_steering_controller_macros.svh"
module line_sensor_steering_controller import lssc_pkg::*; #(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int STOP_TICKS = STOP_TICKS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // tuser: cmd
  input  logic s_tuser,
  // tdata: sample_0 .. sample_N, 10 bits each from the low end
  input  logic [((CHANNELS*SW+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // tdata: left_duty[10:0], right_duty[21:11], position_error[35:22], stopped[36]
  output logic [39:0] m_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [SW-1:0] cfg_data
);
  logic [SW-1:0] kp_q8, base_speed;
  logic busy, out_free;
  logic [$clog2(CHANNELS)-1:0] ch;
  dp_cmd_t cmd;
  dp_stat_t stat;
  logic [DUTY_W-1:0] left_duty, right_duty;
  logic signed [ERR_W-1:0] position_error;
  logic stopped;
  logic in_go;

  assign s_tready = ~busy;
  assign in_go = s_tvalid & s_tready;
  assign cfg_ready = 1'b1;
  assign out_free = ~m_tvalid | m_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_q8 <= KP_RESET;
      base_speed <= BASE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_KP) kp_q8 <= cfg_data;
      else base_speed <= cfg_data;
    end
  end

  lssc_ctrl #(.CHANNELS(CHANNELS)) u_ctrl (
    .clk(clk), .rst(rst), .in_go(in_go), .in_run(s_tuser != CMD_CAL),
    .out_free(out_free), .stat(stat), .busy(busy), .ch(ch), .cmd(cmd)
  );

  lssc_dp #(.CHANNELS(CHANNELS), .STOP_TICKS(STOP_TICKS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .ch(ch), .in_run(s_tuser != CMD_CAL),
    .in_samples(s_tdata[CHANNELS*SW-1:0]), .kp_q8(kp_q8), .base_speed(base_speed),
    .stat(stat), .left_duty(left_duty), .right_duty(right_duty),
    .position_error(position_error), .stopped(stopped)
  );

  // output word valid
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.finish) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end
  assign m_tdata = {3'd0, stopped, position_error, right_duty, left_duty};

  `LSSC_ASSERT(a_no_accept_busy, clk, rst, busy |-> !s_tready)
  `LSSC_ASSERT(a_finish_free, clk, rst, cmd.finish |-> out_free)
  `LSSC_ASSERT(a_stop_zero, clk, rst, (m_tvalid && stopped) |-> (left_duty == '0))
endmodule
